### hdl/toop_pkg.sv
// Package for the terminal option order parser: phase and result codes,
// order opcodes, range limits, the result record and the opcode decoder.
// Depends on nothing; every module of the block imports it.
package toop_pkg;

  localparam int unsigned COLUMNS = 80;
  localparam int unsigned COL_W = $clog2(COLUMNS);

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  localparam logic [7:0] MODE_RESET   = 8'h22;
  localparam logic [7:0] BIAS         = 8'h40;
  localparam logic [7:0] HOME_LIMIT   = 8'd24;
  localparam logic [7:0] MARGIN_LIMIT = 8'd80;
  localparam logic [7:0] COL_LIMIT    = 8'(COLUMNS);
  localparam logic [7:0] NEED_BYTES   = 8'd30;
  localparam logic [4:0] MAX_TABS     = 5'd28;

  localparam logic [7:0] OP_APL_ON      = 8'hA0;
  localparam logic [7:0] OP_APL_OFF     = 8'h61;
  localparam logic [7:0] OP_NULL_OFF    = 8'h95;
  localparam logic [7:0] OP_NULL_ON     = 8'hD5;
  localparam logic [7:0] OP_ZONES_ON    = 8'hA9;
  localparam logic [7:0] OP_ZONES_OFF   = 8'hE9;
  localparam logic [7:0] OP_ENTNL_ON    = 8'h85;
  localparam logic [7:0] OP_ENTNL_OFF   = 8'hC5;
  localparam logic [7:0] OP_CFTAB_ON    = 8'h83;
  localparam logic [7:0] OP_CFTAB_OFF   = 8'hC3;
  localparam logic [7:0] OP_PACING_OFF  = 8'h97;
  localparam logic [7:0] OP_PACING_ON   = 8'hD7;
  localparam logic [7:0] OP_ALPHA_ON    = 8'hA5;
  localparam logic [7:0] OP_ALPHA_OFF   = 8'hE5;
  localparam logic [7:0] OP_WRAP_ON     = 8'hA6;
  localparam logic [7:0] OP_WRAP_OFF    = 8'hE6;
  localparam logic [7:0] OP_TAB_ORDER   = 8'hE3;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HOME   = 2'd1,
    PH_MARGIN = 2'd2,
    PH_TABS   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_DONE = 2'd0,
    KIND_MORE = 2'd1,
    KIND_TAB  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [4:0] consumed;
    logic [7:0] option_flags;
    logic [4:0] home_row;
    logic [6:0] left_margin;
    logic       tab_stop;
  } res_t;

  typedef struct packed {
    logic [7:0] set;
    logic [7:0] clr;
  } mask_t;

  function automatic mask_t op_mask(input logic [7:0] b);
    mask_t m;
    m = '0;
    unique case (b)
      OP_APL_ON:     m.set = 8'h01;
      OP_APL_OFF:    m.clr = 8'h01;
      OP_NULL_OFF:   m.clr = 8'h02;
      OP_NULL_ON:    m.set = 8'h02;
      OP_ZONES_ON:   m.set = 8'h04;
      OP_ZONES_OFF:  m.clr = 8'h04;
      OP_ENTNL_ON:   m.set = 8'h08;
      OP_ENTNL_OFF:  m.clr = 8'h08;
      OP_CFTAB_ON:   m.set = 8'h10;
      OP_CFTAB_OFF:  m.clr = 8'h10;
      OP_PACING_OFF: m.clr = 8'h20;
      OP_PACING_ON:  m.set = 8'h20;
      OP_ALPHA_ON:   m.set = 8'h40;
      OP_ALPHA_OFF:  m.clr = 8'h40;
      OP_WRAP_ON:    m.set = 8'h80;
      OP_WRAP_OFF:   m.clr = 8'h80;
      default:       m = '0;
    endcase
    return m;
  endfunction

  function automatic logic [COLUMNS-1:0] tab_reset();
    logic [COLUMNS-1:0] r;
    for (int i = 0; i < COLUMNS; i++) begin
      r[i] = (i[2:0] == 3'd0);
    end
    return r;
  endfunction

endpackage

### hdl/terminal_option_order_parser_core.sv
// Top level of the terminal option order parser: input register, order
// parser with its settings and tab map, and the result queue.
// Depends on toop_pkg.
//
// Usage: order bytes and tab stop queries arrive on the request channel
// (in_valid_i / in_ready_o); results leave on the result channel
// (out_valid_o / out_ready_i). A request is held in an input register and
// parsed from there; its results are then written to a four-entry queue
// that feeds the result channel. One request can be taken every cycle
// while the queue has room. A request gives zero, one or two results; a
// bad tab byte that is parsed again as an opcode can give two.
// The parse step waits until the queue has room for two results; when the
// receiver stalls, the queue fills and then the input register holds its
// request and in_ready_o drops. Nothing is lost or repeated.
// At reset the queue empties, the parser goes idle, null processing and
// pacing are set, home row and left margin are zero and a tab stop is set
// at every eighth column. No clearing pass is needed after reset.
module terminal_option_order_parser_core
  import toop_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       cmd_i,
  input  logic [7:0] data_byte_i,
  input  logic [7:0] follow_count_i,
  input  logic       control_i,
  input  logic [6:0] query_column_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [4:0] consumed_o,
  output logic [7:0] option_flags_o,
  output logic [4:0] home_row_o,
  output logic [6:0] left_margin_o,
  output logic       tab_stop_o
);

  logic             s1_valid_q;
  logic             cmd_q;
  logic [7:0]       byte_q;
  logic [7:0]       follow_q;
  logic             ctl_q;
  logic [6:0]       qcol_q;

  logic [7:0]         flags_q, flags_d;
  logic [4:0]         home_q, home_d;
  logic [6:0]         margin_q, margin_d;
  logic [COLUMNS-1:0] tab_q, tab_d;
  phase_e             phase_q, phase_d;
  logic [4:0]         obytes_q, obytes_d;
  logic [4:0]         ttaken_q, ttaken_d;

  res_t             fifo_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  logic       fire;
  logic       pop;
  logic       push0, push1;
  res_t       res0, res1;
  logic [7:0] v;
  logic       bad_home, bad_margin, bad_tab;
  logic       do_op, op_slot;
  mask_t      mask;

  assign fire       = s1_valid_q && (count_q <= CNT_W'(FIFO_DEPTH - 2));
  assign in_ready_o = !s1_valid_q || fire;
  assign pop        = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q    <= cmd_i;
      byte_q   <= data_byte_i;
      follow_q <= follow_count_i;
      ctl_q    <= control_i;
      qcol_q   <= query_column_i;
    end
  end

  assign v          = byte_q - BIAS;
  assign bad_home   = (byte_q < BIAS) || (v >= HOME_LIMIT);
  assign bad_margin = (byte_q < BIAS) || (v >= MARGIN_LIMIT);
  assign bad_tab    = (byte_q < BIAS) || (v >= COL_LIMIT);
  assign mask       = op_mask(byte_q);

  // The state variables are updated in model order, so a result built at
  // any point carries the settings as they stand at that point.
  always_comb begin
    flags_d  = flags_q;
    home_d   = home_q;
    margin_d = margin_q;
    tab_d    = tab_q;
    phase_d  = phase_q;
    obytes_d = obytes_q;
    ttaken_d = ttaken_q;
    push0    = 1'b0;
    push1    = 1'b0;
    res0     = '0;
    res1     = '0;
    do_op    = 1'b0;
    op_slot  = 1'b0;

    if (cmd_q) begin
      push0             = 1'b1;
      res0.kind         = KIND_TAB;
      res0.option_flags = flags_d;
      res0.home_row     = home_d;
      res0.left_margin  = margin_d;
      res0.tab_stop = ({1'b0, qcol_q} < COL_LIMIT) ? tab_q[qcol_q[COL_W-1:0]] : 1'b0;
    end else begin
      unique case (phase_q)
        PH_HOME: begin
          obytes_d = obytes_q + 5'd1;
          if (bad_home) begin
            push0 = 1'b1;
          end else begin
            home_d = v[4:0];
            if (follow_q == 8'd0) begin
              push0 = 1'b1;
            end else begin
              phase_d = PH_MARGIN;
            end
          end
        end
        PH_MARGIN: begin
          obytes_d = obytes_q + 5'd1;
          if (bad_margin) begin
            push0 = 1'b1;
          end else begin
            margin_d = v[6:0];
            if (follow_q == 8'd0) begin
              push0 = 1'b1;
            end else begin
              phase_d  = PH_TABS;
              ttaken_d = 5'd0;
            end
          end
        end
        PH_TABS: begin
          if (bad_tab) begin
            push0   = 1'b1;
            do_op   = 1'b1;
            op_slot = 1'b1;
          end else begin
            tab_d[v[COL_W-1:0]] = 1'b1;
            ttaken_d = ttaken_q + 5'd1;
            obytes_d = obytes_q + 5'd1;
            if ((ttaken_d >= MAX_TABS) || (follow_q == 8'd0)) begin
              push0 = 1'b1;
            end
          end
        end
        default: begin
          do_op = 1'b1;
        end
      endcase

      if (push0) begin
        res0.kind         = KIND_DONE;
        res0.consumed     = obytes_d;
        res0.option_flags = flags_d;
        res0.home_row     = home_d;
        res0.left_margin  = margin_d;
        phase_d  = PH_IDLE;
        obytes_d = 5'd0;
        ttaken_d = 5'd0;
      end

      if (do_op) begin
        if (byte_q == OP_TAB_ORDER) begin
          if (!ctl_q && (follow_q < NEED_BYTES)) begin
            res1.kind         = KIND_MORE;
            res1.option_flags = flags_d;
            res1.home_row     = home_d;
            res1.left_margin  = margin_d;
            if (op_slot) begin
              push1 = 1'b1;
            end else begin
              push0 = 1'b1;
              res0  = res1;
            end
          end else begin
            tab_d    = '0;
            obytes_d = 5'd1;
            ttaken_d = 5'd0;
            if (follow_q == 8'd0) begin
              res1.kind         = KIND_DONE;
              res1.consumed     = obytes_d;
              res1.option_flags = flags_d;
              res1.home_row     = home_d;
              res1.left_margin  = margin_d;
              phase_d  = PH_IDLE;
              obytes_d = 5'd0;
              if (op_slot) begin
                push1 = 1'b1;
              end else begin
                push0 = 1'b1;
                res0  = res1;
              end
            end else begin
              phase_d = PH_HOME;
            end
          end
        end else begin
          flags_d           = (flags_d | mask.set) & ~mask.clr;
          res1.kind         = KIND_DONE;
          res1.consumed     = 5'd1;
          res1.option_flags = flags_d;
          res1.home_row     = home_d;
          res1.left_margin  = margin_d;
          phase_d  = PH_IDLE;
          obytes_d = 5'd0;
          ttaken_d = 5'd0;
          if (op_slot) begin
            push1 = 1'b1;
          end else begin
            push0 = 1'b1;
            res0  = res1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q  <= MODE_RESET;
      home_q   <= 5'd0;
      margin_q <= 7'd0;
      tab_q    <= tab_reset();
      phase_q  <= PH_IDLE;
      obytes_q <= 5'd0;
      ttaken_q <= 5'd0;
    end else if (fire) begin
      flags_q  <= flags_d;
      home_q   <= home_d;
      margin_q <= margin_d;
      tab_q    <= tab_d;
      phase_q  <= phase_d;
      obytes_q <= obytes_d;
      ttaken_q <= ttaken_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PTR_W'(fire & push0) + PTR_W'(fire & push1);
      rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
      count_q  <= count_q + CNT_W'(fire & push0) + CNT_W'(fire & push1) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && push0) begin
      fifo_q[wr_ptr_q] <= res0;
    end
    if (fire && push1) begin
      fifo_q[wr_ptr_q + PTR_W'(1)] <= res1;
    end
  end

  assign out_valid_o    = (count_q != '0);
  assign kind_o         = fifo_q[rd_ptr_q].kind;
  assign consumed_o     = fifo_q[rd_ptr_q].consumed;
  assign option_flags_o = fifo_q[rd_ptr_q].option_flags;
  assign home_row_o     = fifo_q[rd_ptr_q].home_row;
  assign left_margin_o  = fifo_q[rd_ptr_q].left_margin;
  assign tab_stop_o     = fifo_q[rd_ptr_q].tab_stop;

endmodule

### hdl/toop_checker.sv
// Port checker for the terminal option order parser, bound to the top level.
// Depends on toop_pkg and on the port list of terminal_option_order_parser_core.
module toop_checker
  import toop_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] kind_o,
  input logic [4:0] consumed_o,
  input logic [7:0] option_flags_o,
  input logic [4:0] home_row_o,
  input logic [6:0] left_margin_o,
  input logic       tab_stop_o
);

  // A stalled result must stay in place until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) &&
    $stable(consumed_o) && $stable(option_flags_o) && $stable(tab_stop_o))
    else $error("stalled result changed");

  // Want-more and tab stop results never report consumed bytes.
  a_no_consume: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_MORE || kind_o == KIND_TAB) |-> consumed_o == 5'd0)
    else $error("consumed count on a result that finishes no order");

  // A finished order always took at least its opcode byte and reads no tab.
  a_done_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_DONE |-> consumed_o != 5'd0 && !tab_stop_o)
    else $error("finished order with no bytes or with a tab bit");

  // Only accepted home row and margin values can ever be shown.
  a_settings_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> home_row_o < 5'd24 && left_margin_o < 7'd80)
    else $error("home row or left margin out of range");

endmodule

bind terminal_option_order_parser_core toop_checker u_toop_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .kind_o         (kind_o),
  .consumed_o     (consumed_o),
  .option_flags_o (option_flags_o),
  .home_row_o     (home_row_o),
  .left_margin_o  (left_margin_o),
  .tab_stop_o     (tab_stop_o)
);
